### rtl/assert_macros.svh
// assertion macros used by double_to_hex_float_text
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/dhf_pkg.sv
// types, constants and character tables for the hex-float text formatter
// no dependencies
package dhf_pkg;

   localparam int VALUE_W  = 64;
   localparam int CHAR_W   = 8;
   localparam int FRAC_W   = 52;
   localparam int BEXP_W   = 11;
   localparam int EXP_SW   = 12;
   localparam int MAG_W    = 11;
   localparam int DIGIT_W  = 4;
   localparam int NPLACE   = 4;
   localparam int ZERO_LEN = 6;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [MAG_W-1:0]   mag_type;

   localparam logic signed [EXP_SW-1:0] EXP_BIAS    = 12'sd1023;
   localparam logic signed [EXP_SW-1:0] EXP_SUB_MIN = -12'sd1022;
   localparam logic [BEXP_W-1:0]        BEXP_ONES   = '1;

   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_ONE   = 8'h31;
   localparam char_type CH_MINUS = 8'h2d;
   localparam char_type CH_PLUS  = 8'h2b;
   localparam char_type CH_DOT   = 8'h2e;
   localparam char_type CH_X     = 8'h78;
   localparam char_type CH_P     = 8'h70;
   localparam char_type CH_A     = 8'h61;

   function automatic char_type hex_char(input digit_type d);
      char_type c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'b0000, d};
      end else begin
         c = CH_A + {4'b0000, d - 4'd10};
      end
      return c;
   endfunction

   // "-0x1", sign only when negative
   function automatic char_type head_char(input logic [1:0] i);
      char_type c;
      case (i)
         2'd0:    c = CH_MINUS;
         2'd1:    c = CH_ZERO;
         2'd2:    c = CH_X;
         default: c = CH_ONE;
      endcase
      return c;
   endfunction

   // "0x0p+0"
   function automatic char_type zero_char(input logic [2:0] i);
      char_type c;
      case (i)
         3'd0:    c = CH_ZERO;
         3'd1:    c = CH_X;
         3'd2:    c = CH_ZERO;
         3'd3:    c = CH_P;
         3'd4:    c = CH_PLUS;
         default: c = CH_ZERO;
      endcase
      return c;
   endfunction

   // decimal place weights for the exponent digits
   function automatic mag_type place_val(input logic [1:0] i);
      mag_type v;
      case (i)
         2'd0:    v = 11'd1000;
         2'd1:    v = 11'd100;
         2'd2:    v = 11'd10;
         default: v = 11'd1;
      endcase
      return v;
   endfunction

endpackage

### rtl/double_to_hex_float_text.sv
// binary64 to hex-float text, one character per beat
// depends on dhf_pkg and assert_macros.svh
//
//  channel   ports                                   handshake
//  request   req_value_bits                          start & !busy
//  response  rsp_text_char rsp_last_char rsp_bad_value  rsp_valid, one cycle
//
// a value passes from accept through the normalizing shifter (a subnormal is shifted
// left one bit per step until its leading one is at the hidden bit), then the subtract
// unit, which counts out the thousands, hundreds and tens exponent digits, to the text:
// up to 24 characters; zero gives the six characters 0x0p+0, inf and nan a single error beat
// busy falls as the last beat reaches the outputs; the receiver cannot stall
// synchronous reset clears the sequencer and the response strobe
`include "assert_macros.svh"

module double_to_hex_float_text (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dhf_pkg::VALUE_W-1:0]    req_value_bits,
   output logic                           rsp_valid,
   output logic [dhf_pkg::CHAR_W-1:0]     rsp_text_char,
   output logic                           rsp_last_char,
   output logic                           rsp_bad_value
);
   import dhf_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_BAD  = 4'd1;
   localparam logic [3:0] S_ZERO = 4'd2;
   localparam logic [3:0] S_NORM = 4'd3;
   localparam logic [3:0] S_DEC  = 4'd4;
   localparam logic [3:0] S_HEAD = 4'd5;
   localparam logic [3:0] S_DOT  = 4'd6;
   localparam logic [3:0] S_FRAC = 4'd7;
   localparam logic [3:0] S_P    = 4'd8;
   localparam logic [3:0] S_ESGN = 4'd9;
   localparam logic [3:0] S_EDIG = 4'd10;

   logic [3:0]               state_ff, state_in;
   logic                     neg_ff, neg_in;
   logic [FRAC_W:0]          mant_ff, mant_in;
   logic signed [EXP_SW-1:0] exp_ff, exp_in;
   logic                     eneg_ff, eneg_in;
   mag_type                  mag_ff, mag_in;
   logic [1:0]               pidx_ff, pidx_in;
   digit_type                dcnt_ff, dcnt_in;
   digit_type                dig_ff [NPLACE];
   digit_type                dig_in [NPLACE];
   logic [2:0]               idx_ff, idx_in;
   logic                     valid_ff, valid_in;
   char_type                 char_ff, char_in;
   logic                     last_ff, last_in;
   logic                     bad_ff, bad_in;

   logic [BEXP_W-1:0]        req_bexp;
   logic [FRAC_W-1:0]        req_frac;
   mag_type                  place;
   logic [1:0]               lead;

   assign req_bexp = req_value_bits[FRAC_W +: BEXP_W];
   assign req_frac = req_value_bits[FRAC_W-1:0];
   assign place    = place_val(pidx_ff);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      if (dig_ff[0] != '0) begin
         lead = 2'd0;
      end else if (dig_ff[1] != '0) begin
         lead = 2'd1;
      end else if (dig_ff[2] != '0) begin
         lead = 2'd2;
      end else begin
         lead = 2'd3;
      end
   end

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mant_in  = mant_ff;
      exp_in   = exp_ff;
      eneg_in  = eneg_ff;
      mag_in   = mag_ff;
      pidx_in  = pidx_ff;
      dcnt_in  = dcnt_ff;
      dig_in   = dig_ff;
      idx_in   = idx_ff;
      valid_in = 1'b0;
      char_in  = CH_NUL;
      last_in  = 1'b0;
      bad_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               neg_in = req_value_bits[VALUE_W-1];
               if (req_bexp == BEXP_ONES) begin
                  state_in = S_BAD;
               end else if (req_bexp == '0 && req_frac == '0) begin
                  idx_in   = 3'd0;
                  state_in = S_ZERO;
               end else if (req_bexp == '0) begin
                  mant_in  = {1'b0, req_frac};
                  exp_in   = EXP_SUB_MIN;
                  state_in = S_NORM;
               end else begin
                  mant_in  = {1'b1, req_frac};
                  exp_in   = $signed({1'b0, req_bexp}) - EXP_BIAS;
                  state_in = S_NORM;
               end
            end
         end
         S_BAD: begin
            valid_in = 1'b1;
            last_in  = 1'b1;
            bad_in   = 1'b1;
            state_in = S_IDLE;
         end
         S_ZERO: begin
            valid_in = 1'b1;
            char_in  = zero_char(idx_ff);
            if (idx_ff == 3'(ZERO_LEN - 1)) begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         S_NORM: begin
            if (mant_ff[FRAC_W]) begin
               eneg_in  = exp_ff[EXP_SW-1];
               mag_in   = exp_ff[EXP_SW-1] ? MAG_W'(-exp_ff) : exp_ff[MAG_W-1:0];
               pidx_in  = 2'd0;
               dcnt_in  = '0;
               state_in = S_DEC;
            end else begin
               mant_in = {mant_ff[FRAC_W-1:0], 1'b0};
               exp_in  = exp_ff - 12'sd1;
            end
         end
         S_DEC: begin
            if (mag_ff >= place) begin
               mag_in  = mag_ff - place;
               dcnt_in = dcnt_ff + 4'd1;
            end else begin
               dig_in[pidx_ff] = dcnt_ff;
               dcnt_in         = '0;
               if (pidx_ff == 2'd2) begin
                  dig_in[3] = mag_ff[DIGIT_W-1:0];
                  idx_in    = neg_ff ? 3'd0 : 3'd1;
                  state_in  = S_HEAD;
               end else begin
                  pidx_in = pidx_ff + 2'd1;
               end
            end
         end
         S_HEAD: begin
            valid_in = 1'b1;
            char_in  = head_char(idx_ff[1:0]);
            if (idx_ff == 3'd3) begin
               state_in = (mant_ff[FRAC_W-1:0] != '0) ? S_DOT : S_P;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         S_DOT: begin
            valid_in = 1'b1;
            char_in  = CH_DOT;
            state_in = S_FRAC;
         end
         S_FRAC: begin
            valid_in = 1'b1;
            char_in  = hex_char(mant_ff[FRAC_W-1 -: DIGIT_W]);
            mant_in  = {mant_ff[FRAC_W], mant_ff[FRAC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            if (mant_ff[FRAC_W-DIGIT_W-1:0] == '0) begin
               state_in = S_P;
            end
         end
         S_P: begin
            valid_in = 1'b1;
            char_in  = CH_P;
            state_in = S_ESGN;
         end
         S_ESGN: begin
            valid_in = 1'b1;
            char_in  = eneg_ff ? CH_MINUS : CH_PLUS;
            pidx_in  = lead;
            state_in = S_EDIG;
         end
         S_EDIG: begin
            valid_in = 1'b1;
            char_in  = CH_ZERO + {4'b0000, dig_ff[pidx_ff]};
            if (pidx_ff == 2'd3) begin
               last_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               pidx_in = pidx_ff + 2'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      neg_ff  <= neg_in;
      mant_ff <= mant_in;
      exp_ff  <= exp_in;
      eneg_ff <= eneg_in;
      mag_ff  <= mag_in;
      pidx_ff <= pidx_in;
      dcnt_ff <= dcnt_in;
      dig_ff  <= dig_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;
   assign rsp_bad_value = bad_ff;

   // a beat only follows a busy cycle
   `ASSERT_CLK(a_beat_from_busy, clock, reset, rsp_valid |-> $past(busy), "beat without work")
   // characters of one value come in an unbroken run
   `ASSERT_CLK(a_run_gapless, clock, reset, (rsp_valid && !rsp_last_char) |=> rsp_valid, "gap in text")
   // the last beat of a value is followed by a quiet cycle
   `ASSERT_CLK(a_last_gap, clock, reset, (rsp_valid && rsp_last_char) |=> !rsp_valid, "beat after last")
   // the error beat is a lone nul character
   `ASSERT_CLK(a_bad_beat, clock, reset, (rsp_valid && rsp_bad_value) |-> (rsp_last_char && rsp_text_char == CH_NUL), "bad beat malformed")
   // an accepted value always makes the block busy
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept without work")

endmodule

### sim/dhf_checker.sv
// checker for the hex-float text formatter: watches the request and response channels,
// predicts the character beats of each accepted value and compares them in order
// depends on dhf_pkg
`timescale 1ns / 100ps

module dhf_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [dhf_pkg::VALUE_W-1:0] req_value_bits,
   input  logic                        rsp_valid,
   input  logic [dhf_pkg::CHAR_W-1:0]  rsp_text_char,
   input  logic                        rsp_last_char,
   input  logic                        rsp_bad_value,
   input  logic                        end_of_run,
   output int                          pending_beats,
   output int                          error_count
);
   import dhf_pkg::*;

   typedef struct {
      char_type ch;
      logic     last;
      logic     bad;
   } text_beat_type;

   text_beat_type text_beats_due [$];
   bit            leftover_checked = 1'b0;

   task automatic flag_mismatch(input string msg);
      if (error_count < 40) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
      error_count += 1;
   endtask

   // text of one binary64 pattern, pushed as character beats
   task automatic queue_hex_text(input logic [VALUE_W-1:0] v);
      logic [BEXP_W-1:0] bexp;
      logic [FRAC_W-1:0] frac;
      int                exp_val;
      int                lead;
      int                ndig;
      string             txt;
      text_beat_type     b;
      bexp = v[62:52];
      frac = v[FRAC_W-1:0];
      if (bexp == BEXP_ONES) begin
         b.ch   = CH_NUL;
         b.last = 1'b1;
         b.bad  = 1'b1;
         text_beats_due.push_back(b);
         return;
      end
      if (bexp == '0 && frac == '0) begin
         txt = "0x0p+0";
      end else begin
         if (bexp == '0) begin
            lead = 0;
            for (int k = 0; k < FRAC_W; k++) begin
               if (frac[k]) begin
                  lead = k;
               end
            end
            exp_val = lead - 1074;
            frac    = frac << (FRAC_W - lead);
         end else begin
            exp_val = int'(bexp) - 1023;
         end
         if (v[63]) begin
            txt = "-0x1";
         end else begin
            txt = "0x1";
         end
         ndig = 13;
         while (ndig > 0 && frac[4*(13-ndig) +: 4] == 4'h0) begin
            ndig -= 1;
         end
         if (ndig > 0) begin
            txt = {txt, "."};
            for (int i = 0; i < ndig; i++) begin
               txt = {txt, $sformatf("%h", frac[48-4*i +: 4])};
            end
         end
         if (exp_val < 0) begin
            txt = {txt, "p-", $sformatf("%0d", -exp_val)};
         end else begin
            txt = {txt, "p+", $sformatf("%0d", exp_val)};
         end
      end
      for (int i = 0; i < txt.len(); i++) begin
         b.ch   = txt[i];
         b.last = (i == txt.len() - 1);
         b.bad  = 1'b0;
         text_beats_due.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      text_beat_type want;
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            if (text_beats_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat char %h last %b bad %b",
                  rsp_text_char, rsp_last_char, rsp_bad_value));
            end else begin
               want = text_beats_due.pop_front();
               if (rsp_text_char !== want.ch) begin
                  flag_mismatch($sformatf("text_char got %h want %h", rsp_text_char, want.ch));
               end
               if (rsp_last_char !== want.last) begin
                  flag_mismatch($sformatf("last_char got %b want %b (char %h)",
                     rsp_last_char, want.last, want.ch));
               end
               if (rsp_bad_value !== want.bad) begin
                  flag_mismatch($sformatf("bad_value got %b want %b (char %h)",
                     rsp_bad_value, want.bad, want.ch));
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            queue_hex_text(req_value_bits);
         end
         if (end_of_run && !leftover_checked) begin
            if (text_beats_due.size() != 0) begin
               flag_mismatch($sformatf("%0d beats never arrived", text_beats_due.size()));
            end
            leftover_checked = 1'b1;
         end
      end
      pending_beats = text_beats_due.size();
   end

endmodule

### sim/double_to_hex_float_text_tb.sv
// testbench top for double_to_hex_float_text: clock, reset, directed and random values,
// idle bursts on the request side, verdict from the checker's failure count
// depends on dhf_pkg, dhf_checker and the block itself
`timescale 1ns / 100ps

module double_to_hex_float_text_tb;
   import dhf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 220;
   localparam int CALM_ITEMS = 30;
   localparam int TAIL_CYCLES = 200;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [VALUE_W-1:0]   req_value_bits;
   logic                 rsp_valid;
   logic [CHAR_W-1:0]    rsp_text_char;
   logic                 rsp_last_char;
   logic                 rsp_bad_value;
   logic                 end_of_run;
   int                   pending_beats;
   int                   error_count;
   int                   cycle_count = 0;
   logic [VALUE_W-1:0]   directed_vals [0:23];

   always #6 clock = ~clock;

   double_to_hex_float_text u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_text_char  (rsp_text_char),
      .rsp_last_char  (rsp_last_char),
      .rsp_bad_value  (rsp_bad_value)
   );

   dhf_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_text_char  (rsp_text_char),
      .rsp_last_char  (rsp_last_char),
      .rsp_bad_value  (rsp_bad_value),
      .end_of_run     (end_of_run),
      .pending_beats  (pending_beats),
      .error_count    (error_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("double_to_hex_float_text test failed");
         $finish;
      end
   end

   // holds start until the value is accepted, then maybe idles for a burst
   task automatic send_value(input logic [VALUE_W-1:0] v, input bit may_idle);
      start          <= 1'b1;
      req_value_bits <= v;
      @(negedge clock);
      while (busy !== 1'b0) begin
         @(negedge clock);
      end
      @(posedge clock);
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start          <= 1'b0;
         req_value_bits <= {$urandom, $urandom};
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_beats != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   initial begin
      logic [VALUE_W-1:0] v;
      logic [FRAC_W-1:0]  frac;
      logic [FRAC_W-1:0]  fmask;
      logic [BEXP_W-1:0]  bexp;
      int                 pick;
      reset          = 1'b1;
      start          = 1'b0;
      req_value_bits = '0;
      end_of_run     = 1'b0;
      directed_vals = '{
         64'h0000000000000000, 64'h8000000000000000, 64'h7ff0000000000000,
         64'hfff0000000000000, 64'h7ff8000000000000, 64'h7ff0000000000001,
         64'hffffffffffffffff, 64'h3ff0000000000000, 64'hbff0000000000000,
         64'h7fefffffffffffff, 64'h0010000000000000, 64'h0000000000000001,
         64'h000fffffffffffff, 64'h8000000000000001, 64'h0008000000000000,
         64'h7e60000000000000, 64'h0180000000000000, 64'h4080000000000000,
         64'h3fe0000000000000, 64'h3ff8000000000000, 64'h3ff0000000000001,
         64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'h800fedcba9876543
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vals[i]) begin
         send_value(directed_vals[i], 1'b1);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         v    = {$urandom, $urandom};
         frac = v[FRAC_W-1:0];
         bexp = v[62:52];
         if (pick < 30) begin
            // any pattern
         end else if (pick < 55) begin
            // normal, random count of trailing zero digits
            bexp  = BEXP_W'($urandom_range(1, 2046));
            fmask = '1;
            frac  = frac & (fmask << (4 * $urandom_range(0, 13)));
         end else if (pick < 70) begin
            bexp = '0;
            frac = frac >> $urandom_range(0, 51);
            if (frac == '0) begin
               frac = FRAC_W'(1);
            end
         end else if (pick < 80) begin
            bexp = BEXP_W'($urandom_range(1013, 1033));
         end else if (pick < 88) begin
            bexp = '0;
            frac = '0;
         end else if (pick < 94) begin
            bexp = BEXP_ONES;
            if ($urandom_range(0, 1) == 0) begin
               frac = '0;
            end
         end else begin
            case ($urandom_range(0, 3))
               0:       bexp = BEXP_W'(1);
               1:       bexp = BEXP_W'(2046);
               2:       bexp = BEXP_W'(24);
               default: bexp = BEXP_W'(2022);
            endcase
         end
         v = {v[63], bexp, frac};
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            wait_drained();
         end
         send_value(v, n < RANDOM_ITEMS - CALM_ITEMS);
      end
      start <= 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0) begin
         $display("double_to_hex_float_text test passed");
      end else begin
         $display("double_to_hex_float_text test failed");
      end
      $finish;
   end

endmodule
